FILE: hw/rtl/nlst_pkg.sv
// Shared types, codes and constants of the node loss statistics table.
package nlst_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam logic [15:0] GAP_LIMIT_RESET = 16'd100;
  localparam logic [8:0]  HOP_KEEP = 9'h1FF;
  localparam int unsigned IN_W  = 336;
  localparam int unsigned OUT_W = 248;

  // Request codes
  localparam logic [2:0] REQ_REPORT      = 3'd0;
  localparam logic [2:0] REQ_MESSAGE     = 3'd1;
  localparam logic [2:0] REQ_SEEN        = 3'd2;
  localparam logic [2:0] REQ_SET_FLAGS   = 3'd3;
  localparam logic [2:0] REQ_CLEAR_FLAGS = 3'd4;
  localparam logic [2:0] REQ_REMOVE      = 3'd5;
  localparam logic [2:0] REQ_RESET_ALL   = 3'd6;

  // Result status codes
  localparam logic [1:0] STAT_EXISTING = 2'd0;
  localparam logic [1:0] STAT_CREATED  = 2'd1;
  localparam logic [1:0] STAT_NONE     = 2'd2;

  // Flag bits
  localparam logic [7:0] FL_UP     = 8'h04;
  localparam logic [7:0] FL_DOWN   = 8'h08;
  localparam logic [7:0] FL_PARENT = 8'h10;

  // One stored node record
  typedef struct packed {
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [63:0] par_hi;
    logic [63:0] par_lo;
    logic [7:0]  flags;
    logic [7:0]  hops;
    logic [31:0] recv;
    logic [31:0] sent;
    logic [31:0] up_lost;
    logic [31:0] down_lost;
    logic [31:0] switches;
    logic [15:0] last_up;
    logic [15:0] last_down;
    logic [31:0] seen_time;
    logic [31:0] start_time;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_UPDATE,
    ST_RA_RD,
    ST_RA_WR,
    ST_EMIT_NONE
  } st_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic clr_idx;
    logic inc_idx;
    logic rd_en;
    logic cmp_step;
    logic take_hit;
    logic take_new;
    logic commit;
    logic ra_wr;
    logic emit_none;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] req;
    logic       match;
    logic       last_idx;
    logic       free_avail;
    logic       out_free;
  } sts_t;

endpackage

FILE: hw/rtl/nlst_ctrl.sv
// Sequencing state machine of the node loss statistics table.
module nlst_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic [2:0]     s_req,
  output logic           s_tready,
  input  nlst_pkg::sts_t sts,
  output nlst_pkg::cmd_t cmd
);
  import nlst_pkg::*;

  st_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_req == REQ_RESET_ALL) begin
            state_next = ST_RA_RD;
          end else if (s_req inside {REQ_REPORT, REQ_MESSAGE, REQ_SEEN, REQ_SET_FLAGS,
                                     REQ_CLEAR_FLAGS, REQ_REMOVE}) begin
            state_next = ST_SRCH_RD;
          end else begin
            state_next = ST_EMIT_NONE;
          end
        end
      end
      ST_SRCH_RD: state_next = ST_SRCH_CMP;
      ST_SRCH_CMP: begin
        if (sts.match) begin
          state_next = ST_UPDATE;
        end else if (sts.last_idx) begin
          if (sts.req == REQ_SEEN || sts.req == REQ_REMOVE || !sts.free_avail) begin
            state_next = ST_EMIT_NONE;
          end else begin
            state_next = ST_UPDATE;
          end
        end else begin
          state_next = ST_SRCH_RD;
        end
      end
      ST_UPDATE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_RA_RD: state_next = ST_RA_WR;
      ST_RA_WR: state_next = sts.last_idx ? ST_EMIT_NONE : ST_RA_RD;
      ST_EMIT_NONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load_in = s_tvalid;
        cmd.clr_idx = 1'b1;
      end
      ST_SRCH_RD: cmd.rd_en = 1'b1;
      ST_SRCH_CMP: begin
        cmd.cmp_step = 1'b1;
        if (sts.match) begin
          cmd.take_hit = 1'b1;
        end else if (sts.last_idx) begin
          cmd.take_new = !(sts.req == REQ_SEEN || sts.req == REQ_REMOVE || !sts.free_avail);
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      ST_UPDATE: cmd.commit = sts.out_free;
      ST_RA_RD: cmd.rd_en = 1'b1;
      ST_RA_WR: begin
        cmd.ra_wr = 1'b1;
        cmd.inc_idx = !sts.last_idx;
      end
      ST_EMIT_NONE: cmd.emit_none = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: hw/rtl/nlst_dp.sv
// Record store, search compare, update arithmetic and result register.
module nlst_dp #(
  parameter int unsigned TABLE_DEPTH = nlst_pkg::DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [nlst_pkg::IN_W-1:0] s_tdata,
  input  logic [2:0]                s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [nlst_pkg::OUT_W-1:0] m_tdata,
  output logic [1:0]                m_tuser,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [15:0]               cfg_data,
  input  nlst_pkg::cmd_t            cmd,
  output nlst_pkg::sts_t            sts
);
  import nlst_pkg::*;

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

  logic [15:0]   gap_limit;
  logic [2:0]    req;
  logic [63:0]   in_ahi, in_alo, in_phi, in_plo;
  logic [31:0]   in_now;
  logic [15:0]   in_up, in_down;
  logic          in_pok, in_dpres;
  logic [8:0]    in_arg;
  logic [IW-1:0] idx, free_idx, slot;
  logic          free_found;
  logic [TABLE_DEPTH-1:0] used;
  rec_t          mem [TABLE_DEPTH];
  rec_t          rd_rec, cur, nrec, fresh, ra_rec, wdata;
  logic          we;
  logic [IW-1:0] waddr;
  logic [1:0]    status_r;
  logic [1:0]    o_status;
  logic [3:0]    o_slot;
  rec_t          o_rec;

  // Gap limit register; writes are taken in any cycle
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit <= GAP_LIMIT_RESET;
    end else if (cfg_valid) begin
      gap_limit <= cfg_data;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req      <= s_tuser;
      in_ahi   <= s_tdata[63:0];
      in_alo   <= s_tdata[127:64];
      in_now   <= s_tdata[159:128];
      in_up    <= s_tdata[175:160];
      in_phi   <= s_tdata[239:176];
      in_plo   <= s_tdata[303:240];
      in_pok   <= s_tdata[304];
      in_dpres <= s_tdata[305];
      in_down  <= s_tdata[321:306];
      in_arg   <= s_tdata[330:322];
    end
  end

  // Scan index and first free slot
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      free_found <= 1'b0;
    end else if (cmd.clr_idx) begin
      idx        <= '0;
      free_found <= 1'b0;
    end else begin
      if (cmd.inc_idx) begin
        idx <= idx + 1'b1;
      end
      if (cmd.cmp_step && !used[idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
    end
  end

  // Record memory: registered read, one write port
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_rec <= mem[idx];
    end
  end
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Used bits
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.commit) begin
      used[slot] <= (req != REQ_REMOVE);
    end else if (cmd.take_new) begin
      used[free_found ? free_idx : idx] <= 1'b1;
    end
  end

  // Status towards the controller
  always_comb begin
    sts.req        = req;
    sts.match      = used[idx] && rd_rec.key_hi == in_ahi && rd_rec.key_lo == in_alo;
    sts.last_idx   = (idx == LAST);
    sts.free_avail = free_found || !used[idx];
    sts.out_free   = !m_tvalid || m_tready;
  end

  // A newly created record
  always_comb begin
    fresh = '0;
    fresh.key_hi = in_ahi;
    fresh.key_lo = in_alo;
    fresh.start_time = in_now;
  end

  // Working record and the slot it belongs to
  always_ff @(posedge clk) begin
    if (cmd.take_hit) begin
      cur      <= rd_rec;
      slot     <= idx;
      status_r <= STAT_EXISTING;
    end else if (cmd.take_new) begin
      cur      <= fresh;
      slot     <= free_found ? free_idx : idx;
      status_r <= STAT_CREATED;
    end
  end

  // Update arithmetic for the request
  logic [63:0] p_hi, p_lo;
  logic [15:0] down_v, delta;
  logic [31:0] recv_n;
  always_comb begin
    nrec   = cur;
    p_hi   = in_pok ? in_phi : 64'd0;
    p_lo   = in_pok ? in_plo : 64'd0;
    down_v = in_dpres ? in_down : 16'd0;
    recv_n = cur.recv + 32'd1;
    delta  = in_up - cur.last_up;
    case (req)
      REQ_REPORT: begin
        nrec.seen_time = in_now;
        nrec.recv = recv_n;
        nrec.flags = (cur.flags | FL_UP) & ~(FL_PARENT | FL_DOWN);
        if (in_pok) begin
          nrec.flags = nrec.flags | FL_PARENT;
        end
        if (in_dpres) begin
          nrec.flags = nrec.flags | FL_DOWN;
        end
        if (cur.par_hi != p_hi || cur.par_lo != p_lo) begin
          nrec.par_hi = p_hi;
          nrec.par_lo = p_lo;
          if (recv_n > 32'd1) begin
            nrec.switches = cur.switches + 32'd1;
          end
        end
        if (recv_n > 32'd1 && delta < gap_limit) begin
          nrec.sent = cur.sent + 32'(delta);
          nrec.up_lost = cur.up_lost + 32'(delta) - 32'd1;
          if (in_dpres && {1'b0, down_v} != {1'b0, cur.last_down} + 17'd1) begin
            nrec.down_lost = cur.down_lost + 32'd1;
          end
        end else begin
          nrec.sent = 32'd1;
          nrec.up_lost = 32'd0;
          nrec.down_lost = 32'd0;
        end
        nrec.last_up = in_up;
        nrec.last_down = down_v;
      end
      REQ_MESSAGE: begin
        nrec.seen_time = in_now;
        nrec.flags = cur.flags & ~(FL_UP | FL_DOWN | FL_PARENT);
        nrec.last_up = 16'd0;
        nrec.last_down = 16'd0;
        nrec.par_hi = 64'd0;
        nrec.par_lo = 64'd0;
      end
      REQ_SEEN: begin
        nrec.seen_time = in_now;
        if (in_arg != HOP_KEEP) begin
          nrec.hops = in_arg[7:0];
        end
      end
      REQ_SET_FLAGS: begin
        nrec.seen_time = in_now;
        nrec.flags = cur.flags | in_arg[7:0];
      end
      REQ_CLEAR_FLAGS: begin
        nrec.seen_time = in_now;
        nrec.flags = cur.flags & ~in_arg[7:0];
      end
      default: nrec = cur;
    endcase
  end

  // Statistics restart for the reset-all sweep
  always_comb begin
    ra_rec = rd_rec;
    ra_rec.start_time = in_now;
    ra_rec.recv = 32'd0;
    ra_rec.sent = 32'd0;
    ra_rec.up_lost = 32'd0;
    ra_rec.down_lost = 32'd0;
    ra_rec.switches = 32'd0;
  end

  // Write port selection
  always_comb begin
    we    = 1'b0;
    waddr = slot;
    wdata = nrec;
    if (cmd.ra_wr) begin
      we    = used[idx];
      waddr = idx;
      wdata = ra_rec;
    end else if (cmd.commit) begin
      we    = (req != REQ_REMOVE);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit || cmd.emit_none) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      o_status <= status_r;
      o_slot   <= 4'(slot);
      o_rec    <= nrec;
    end else if (cmd.emit_none) begin
      o_status <= STAT_NONE;
      o_slot   <= 4'd0;
      o_rec    <= '0;
    end
  end

  assign m_tuser = o_status;
  assign m_tdata = {4'd0, o_rec.start_time, o_rec.seen_time, o_rec.hops, o_rec.switches,
                    o_rec.down_lost, o_rec.up_lost, o_rec.sent, o_rec.recv, o_rec.flags,
                    o_slot};

  // Checks
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit || cmd.emit_none) |-> (!m_tvalid || m_tready))
    else $error("result loaded over an unaccepted result");
  a_new_no_match: assert property (@(posedge clk) disable iff (rst)
    cmd.take_new |-> !sts.match && sts.free_avail)
    else $error("entry created although a match or no free slot");
  a_used_after_commit: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && req != REQ_REMOVE) |=> used[$past(slot)])
    else $error("committed entry not marked used");
  a_remove_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && req == REQ_REMOVE) |=> !used[$past(slot)])
    else $error("removed entry still marked used");

endmodule

FILE: hw/rtl/node_loss_statistics_table.sv
// Node loss statistics table: top level joining controller and datapath.
//
// Requests enter on the s_ stream: s_tuser carries the request code, s_tdata the
// address, time stamp, sequence numbers, parent address and argument. Each
// request gives exactly one result on the m_ stream: m_tuser is the status,
// m_tdata the slot and the entry's flags, counters, hop count and times.
// The gap limit is written on the cfg_ channel, one register, no address.
// One request is handled at a time. A lookup reads the record memory once per
// entry and compares in the following cycle. Reset-all sweeps every entry with
// a read and writes back each used one. A request code with no meaning goes
// from idle straight to the state that loads its none result. The next request
// is taken in the cycle after a result is loaded.
// The result sits in an output register. s_tready is high whenever the
// controller is idle, so a new request may be searched while a result waits;
// the block then holds before loading its result until the receiver has taken
// the pending one, and s_tready stays low meanwhile.
// Reset clears the used bits, the output valid and sets the gap limit to 100;
// no clearing pass is needed.
module node_loss_statistics_table #(
  parameter int unsigned TABLE_DEPTH = nlst_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // addr_high, addr_low, now, up_seq, parent_high, parent_low, parent_ok,
  // down_present, down_seq, arg_value, zero fill
  input  logic [nlst_pkg::IN_W-1:0]   s_tdata,
  // req_type
  input  logic [2:0]                  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // slot, node_flags, received_count, sent_count, up_lost_count,
  // down_lost_count, parent_switch_count, hops, seen_time, start_time, zero fill
  output logic [nlst_pkg::OUT_W-1:0]  m_tdata,
  // status
  output logic [1:0]                  m_tuser,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [15:0]                 cfg_data
);
  import nlst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  nlst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_req    (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nlst_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench of the node loss statistics table.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nlst_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  // One request as seen by the block.
  typedef struct {
    logic [2:0]  req;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [31:0] now;
    logic [15:0] up_seq;
    logic [63:0] par_hi;
    logic [63:0] par_lo;
    logic        par_ok;
    logic        down_ok;
    logic [15:0] down_seq;
    logic [8:0]  arg;
  } nreq_t;

  // One result as produced by the block.
  typedef struct {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [7:0]  flags;
    logic [31:0] recv;
    logic [31:0] sent;
    logic [31:0] up_lost;
    logic [31:0] down_lost;
    logic [31:0] switches;
    logic [7:0]  hops;
    logic [31:0] seen_time;
    logic [31:0] start_time;
  } nres_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  node_loss_statistics_table #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the table.
  logic [15:0] mdl_gap_limit;
  logic        mdl_used [DEPTH];
  rec_t        mdl_rec [DEPTH];

  nres_t expected_results[$];
  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  int unsigned requests_sent = 0;
  int unsigned idle_cycles = 0;
  bit stall_enable = 1'b1;
  bit gap_enable = 1'b1;
  int unsigned hold_off = 0;
  int unsigned stall_burst = 0;

  // Small address pool so that lookups hit, create and fill the table.
  logic [63:0] pool_hi [24];
  logic [63:0] pool_lo [24];

  function automatic nres_t result_of(logic [1:0] st, int idx);
    nres_t r;
    r = '{default: '0};
    r.status = st;
    if (idx >= 0) begin
      r.slot = idx[3:0];
      r.flags = mdl_rec[idx].flags;
      r.recv = mdl_rec[idx].recv;
      r.sent = mdl_rec[idx].sent;
      r.up_lost = mdl_rec[idx].up_lost;
      r.down_lost = mdl_rec[idx].down_lost;
      r.switches = mdl_rec[idx].switches;
      r.hops = mdl_rec[idx].hops;
      r.seen_time = mdl_rec[idx].seen_time;
      r.start_time = mdl_rec[idx].start_time;
    end
    return r;
  endfunction

  // Apply a report to entry idx.
  task automatic apply_report(int idx, nreq_t q);
    logic [63:0] ph, pl;
    logic [15:0] dn;
    logic [15:0] gap;
    ph = '0;
    pl = '0;
    dn = '0;
    mdl_rec[idx].recv = mdl_rec[idx].recv + 1;
    mdl_rec[idx].flags = mdl_rec[idx].flags | FL_UP;
    if (q.par_ok) begin
      ph = q.par_hi;
      pl = q.par_lo;
      mdl_rec[idx].flags = mdl_rec[idx].flags | FL_PARENT;
    end else begin
      mdl_rec[idx].flags = mdl_rec[idx].flags & ~FL_PARENT;
    end
    if (mdl_rec[idx].par_hi != ph || mdl_rec[idx].par_lo != pl) begin
      mdl_rec[idx].par_hi = ph;
      mdl_rec[idx].par_lo = pl;
      if (mdl_rec[idx].recv > 1) mdl_rec[idx].switches = mdl_rec[idx].switches + 1;
    end
    if (q.down_ok) begin
      dn = q.down_seq;
      mdl_rec[idx].flags = mdl_rec[idx].flags | FL_DOWN;
    end else begin
      mdl_rec[idx].flags = mdl_rec[idx].flags & ~FL_DOWN;
    end
    gap = q.up_seq - mdl_rec[idx].last_up;
    if (mdl_rec[idx].recv > 1 && gap < mdl_gap_limit) begin
      mdl_rec[idx].sent = mdl_rec[idx].sent + {16'd0, gap};
      mdl_rec[idx].up_lost = mdl_rec[idx].up_lost + {16'd0, gap} - 32'd1;
      // The successor is taken in 17 bits, so a wrap to zero counts as a loss.
      if ((mdl_rec[idx].flags & FL_DOWN) != 0 &&
          {1'b0, dn} != {1'b0, mdl_rec[idx].last_down} + 17'd1)
        mdl_rec[idx].down_lost = mdl_rec[idx].down_lost + 1;
    end else begin
      mdl_rec[idx].sent = 32'd1;
      mdl_rec[idx].up_lost = '0;
      mdl_rec[idx].down_lost = '0;
    end
    mdl_rec[idx].last_up = q.up_seq;
    mdl_rec[idx].last_down = dn;
  endtask

  // Predict the result of one request and update the shadow table.
  task automatic predict_request(nreq_t q);
    int hit, free_idx;
    logic [1:0] st;
    hit = -1;
    free_idx = -1;
    st = STAT_EXISTING;
    if (q.req == REQ_RESET_ALL) begin
      for (int k = 0; k < DEPTH; k++) begin
        if (mdl_used[k]) begin
          mdl_rec[k].start_time = q.now;
          mdl_rec[k].recv = '0;
          mdl_rec[k].sent = '0;
          mdl_rec[k].up_lost = '0;
          mdl_rec[k].down_lost = '0;
          mdl_rec[k].switches = '0;
        end
      end
      expected_results.push_back(result_of(STAT_NONE, -1));
      return;
    end
    if (q.req > REQ_RESET_ALL) begin
      expected_results.push_back(result_of(STAT_NONE, -1));
      return;
    end
    for (int k = 0; k < DEPTH; k++) begin
      if (mdl_used[k]) begin
        if (hit < 0 && mdl_rec[k].key_hi == q.addr_hi && mdl_rec[k].key_lo == q.addr_lo)
          hit = k;
      end else if (free_idx < 0 && hit < 0) begin
        free_idx = k;
      end
    end
    if (hit < 0) begin
      if (q.req == REQ_SEEN || q.req == REQ_REMOVE || free_idx < 0) begin
        expected_results.push_back(result_of(STAT_NONE, -1));
        return;
      end
      hit = free_idx;
      mdl_used[hit] = 1'b1;
      mdl_rec[hit] = '0;
      mdl_rec[hit].key_hi = q.addr_hi;
      mdl_rec[hit].key_lo = q.addr_lo;
      mdl_rec[hit].start_time = q.now;
      st = STAT_CREATED;
    end
    case (q.req)
      REQ_REPORT: begin
        mdl_rec[hit].seen_time = q.now;
        apply_report(hit, q);
      end
      REQ_MESSAGE: begin
        mdl_rec[hit].seen_time = q.now;
        mdl_rec[hit].flags = mdl_rec[hit].flags & ~(FL_UP | FL_DOWN | FL_PARENT);
        mdl_rec[hit].last_up = '0;
        mdl_rec[hit].last_down = '0;
        mdl_rec[hit].par_hi = '0;
        mdl_rec[hit].par_lo = '0;
      end
      REQ_SEEN: begin
        mdl_rec[hit].seen_time = q.now;
        if (q.arg != HOP_KEEP) mdl_rec[hit].hops = q.arg[7:0];
      end
      REQ_SET_FLAGS: begin
        mdl_rec[hit].seen_time = q.now;
        mdl_rec[hit].flags = mdl_rec[hit].flags | q.arg[7:0];
      end
      REQ_CLEAR_FLAGS: begin
        mdl_rec[hit].seen_time = q.now;
        mdl_rec[hit].flags = mdl_rec[hit].flags & ~q.arg[7:0];
      end
      default: mdl_used[hit] = 1'b0;
    endcase
    expected_results.push_back(result_of(st, hit));
  endtask

  // Random idle gap between requests now and then.
  task automatic maybe_gap();
    if (gap_enable && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 17)) @(posedge clk);
  endtask

  // Send one request and record what it should produce. The block cannot take
  // a request in the cycle after one is taken, so the closing edge costs nothing.
  task automatic send_request(nreq_t q);
    maybe_gap();
    s_tvalid <= 1'b1;
    s_tuser <= q.req;
    s_tdata <= {{(IN_W - 331){1'b0}}, q.arg, q.down_seq, q.down_ok, q.par_ok,
                q.par_lo, q.par_hi, q.up_seq, q.now, q.addr_lo, q.addr_hi};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_request(q);
    requests_sent++;
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (expected_results.size() != 0) @(posedge clk);
    // Every accepted request has had its result taken; the wait below is extra margin.
    repeat (2 * DEPTH + 8) @(posedge clk);
  endtask

  task automatic write_gap_limit(logic [15:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mdl_gap_limit = value;
  endtask

  function automatic nreq_t blank_request(logic [2:0] code, int who);
    nreq_t q;
    q = '{default: '0};
    q.req = code;
    q.addr_hi = pool_hi[who];
    q.addr_lo = pool_lo[who];
    q.now = $urandom;
    q.arg = HOP_KEEP;
    return q;
  endfunction

  function automatic nreq_t random_request(int unsigned pool_n);
    nreq_t q;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    q = blank_request(REQ_REPORT, $urandom_range(0, pool_n - 1));
    if (pick < 55) q.req = REQ_REPORT;
    else if (pick < 62) q.req = REQ_MESSAGE;
    else if (pick < 70) q.req = REQ_SEEN;
    else if (pick < 76) q.req = REQ_SET_FLAGS;
    else if (pick < 82) q.req = REQ_CLEAR_FLAGS;
    else if (pick < 92) q.req = REQ_REMOVE;
    else if (pick < 95) q.req = REQ_RESET_ALL;
    else if (pick < 97) q.req = REQ_UNUSED;
    else begin
      // Fresh random address, mostly a miss.
      q.req = 3'($urandom_range(0, 7));
      q.addr_hi = {$urandom, $urandom};
      q.addr_lo = {$urandom, $urandom};
    end
    // Mostly small sequence steps, sometimes any value.
    q.up_seq = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    q.par_ok = $urandom_range(0, 3) != 0;
    q.par_hi = ($urandom_range(0, 1) != 0) ? pool_hi[0] : {$urandom, $urandom};
    q.par_lo = ($urandom_range(0, 1) != 0) ? pool_lo[1] : {$urandom, $urandom};
    q.down_ok = 1'($urandom_range(0, 1));
    q.down_seq = 16'($urandom);
    q.arg = ($urandom_range(0, 4) == 0) ? HOP_KEEP : 9'($urandom);
    return q;
  endfunction

  // Report streams per node: consecutive sequences with occasional loss.
  task automatic run_stream(int unsigned count);
    logic [15:0] up_next [24];
    logic [15:0] down_next [24];
    nreq_t q;
    int who;
    for (int k = 0; k < 24; k++) begin
      up_next[k] = 16'($urandom);
      down_next[k] = 16'($urandom);
    end
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_request(random_request(24));
      end else begin
        who = $urandom_range(0, 19);
        q = random_request(24);
        q.req = REQ_REPORT;
        q.addr_hi = pool_hi[who];
        q.addr_lo = pool_lo[who];
        up_next[who] = up_next[who] + 16'($urandom_range(1, 3));
        down_next[who] = down_next[who] + 16'($urandom_range(0, 5) == 0 ? 2 : 1);
        q.up_seq = up_next[who];
        q.down_seq = down_next[who];
        send_request(q);
      end
    end
  endtask

  // Extremes of every field, every request code and the special cases.
  task automatic test_directed();
    nreq_t q;
    q = blank_request(REQ_SEEN, 0);
    send_request(q);                          // seen on empty table: none
    q = blank_request(REQ_REMOVE, 0);
    send_request(q);                          // remove of unknown node
    q = blank_request(REQ_REPORT, 0);
    q.addr_hi = '1; q.addr_lo = '1; q.now = '1; q.up_seq = 16'hFFFF;
    q.par_ok = 1'b1; q.par_hi = '1; q.par_lo = '1; q.down_ok = 1'b1;
    q.down_seq = 16'hFFFF;
    send_request(q);                          // first report creates the entry
    q.up_seq = 16'hFFFF; q.down_seq = 16'h0000; q.par_hi = '0;
    send_request(q);                          // zero gap, down wrap, parent switch
    q.up_seq = 16'd0; q.par_ok = 1'b0; q.down_ok = 1'b0;
    send_request(q);
    q.up_seq = 16'd200;
    send_request(q);                          // gap over the limit restarts
    q = blank_request(REQ_SEEN, 0);
    q.addr_hi = '1; q.addr_lo = '1; q.arg = 9'h0FF;
    send_request(q);
    q.arg = HOP_KEEP;
    send_request(q);
    q.arg = 9'h100;
    send_request(q);                          // hop keeps only the low byte
    q.req = REQ_SET_FLAGS; q.arg = 9'h1FF;
    send_request(q);
    q.req = REQ_CLEAR_FLAGS; q.arg = 9'h0AA;
    send_request(q);
    q.req = REQ_MESSAGE;
    send_request(q);
    q = blank_request(REQ_RESET_ALL, 0);
    send_request(q);
    q = blank_request(REQ_UNUSED, 0);
    send_request(q);                          // unused code
    q = blank_request(REQ_REMOVE, 0);
    q.addr_hi = '1; q.addr_lo = '1;
    send_request(q);
    // Fill the table, then one more node finds it full.
    for (int k = 0; k < DEPTH + 1; k++) begin
      q = blank_request(REQ_SET_FLAGS, k);
      q.arg = 9'h001;
      send_request(q);
    end
  endtask

  task automatic test_gap_limits();
    write_gap_limit(16'hFFFF);
    run_stream(250);
    write_gap_limit(16'd1);
    run_stream(150);
    write_gap_limit(16'd0);                   // every report restarts
    run_stream(100);
    write_gap_limit(16'd3);
    run_stream(200);
    write_gap_limit(GAP_LIMIT_RESET);
  endtask

  // Receiver holds off while requests keep coming, then the sender waits.
  task automatic test_back_pressure();
    hold_off = 400;
    run_stream(40);
    drain_results();
  endtask

  task automatic test_random();
    nreq_t q;
    for (int n = 0; n < 450; n++) begin
      q = random_request(24);
      send_request(q);
    end
    stall_enable = 1'b0;
    gap_enable = 1'b0;
    run_stream(250);
  endtask

  // Receiver side: random stalls, stall bursts and the long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else if (stall_burst != 0) begin
      m_tready <= 1'b0;
    end else if (stall_enable && $urandom_range(0, 9) == 0) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Longer receiver stalls in bursts.
  always @(posedge clk) begin
    if (stall_enable && stall_burst == 0 && $urandom_range(0, 40) == 0)
      stall_burst <= $urandom_range(1, 17);
    else if (stall_burst != 0)
      stall_burst <= stall_burst - 1;
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    nres_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      got.status = m_tuser;
      {got.start_time, got.seen_time, got.hops, got.switches, got.down_lost,
       got.up_lost, got.sent, got.recv, got.flags, got.slot} = m_tdata[243:0];
      if (expected_results.size() == 0) begin
        $error("result with no request pending");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status) begin
          $error("status expected %0d got %0d", want.status, got.status); fail_count++;
        end
        if (got.slot != want.slot) begin
          $error("slot expected %0d got %0d", want.slot, got.slot); fail_count++;
        end
        if (got.flags != want.flags) begin
          $error("node_flags expected %h got %h", want.flags, got.flags); fail_count++;
        end
        if (got.recv != want.recv) begin
          $error("received_count expected %0d got %0d", want.recv, got.recv); fail_count++;
        end
        if (got.sent != want.sent) begin
          $error("sent_count expected %0d got %0d", want.sent, got.sent); fail_count++;
        end
        if (got.up_lost != want.up_lost) begin
          $error("up_lost_count expected %0d got %0d", want.up_lost, got.up_lost);
          fail_count++;
        end
        if (got.down_lost != want.down_lost) begin
          $error("down_lost_count expected %0d got %0d", want.down_lost, got.down_lost);
          fail_count++;
        end
        if (got.switches != want.switches) begin
          $error("parent_switch_count expected %0d got %0d", want.switches, got.switches);
          fail_count++;
        end
        if (got.hops != want.hops) begin
          $error("hops expected %0d got %0d", want.hops, got.hops); fail_count++;
        end
        if (got.seen_time != want.seen_time) begin
          $error("seen_time expected %h got %h", want.seen_time, got.seen_time);
          fail_count++;
        end
        if (got.start_time != want.start_time) begin
          $error("start_time expected %h got %h", want.start_time, got.start_time);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request, result or write.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    mdl_gap_limit = GAP_LIMIT_RESET;
    for (int k = 0; k < DEPTH; k++) begin
      mdl_used[k] = 1'b0;
      mdl_rec[k] = '0;
    end
    for (int k = 0; k < 24; k++) begin
      pool_hi[k] = (k % 3 == 0) ? {$urandom, $urandom} : 64'(k);
      pool_lo[k] = {$urandom, $urandom};
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_gap_limits();
    test_back_pressure();
    test_random();
    drain_results();
    $display("Covered %0d requests and %0d results over gap limits 0, 1, 3, 100 and 65535,",
             requests_sent, results_seen);
    $display("with a full table, removals, reset-all and a long receiver stall.");
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
